// File: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token kinds, byte constants and limits shared by the source text
// tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Longest lexeme that is counted; the count saturates at the cap, which is
	// limited to what the 8-bit length field can carry.
	localparam int MAX_LEXEME = 255;
	localparam logic [7:0] LEN_CAP = (MAX_LEXEME < 255) ? 8'(MAX_LEXEME) : 8'd255;

	// Default depth of the bundle queue between front and back end.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_CHAR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ENABLE = 1'd1;

	// Token kinds.
	localparam logic [3:0] K_INT    = 4'd0;
	localparam logic [3:0] K_IDENT  = 4'd1;
	localparam logic [3:0] K_STRING = 4'd2;
	localparam logic [3:0] K_SEMI   = 4'd3;
	localparam logic [3:0] K_COMMA  = 4'd4;
	localparam logic [3:0] K_OPEN   = 4'd5;
	localparam logic [3:0] K_CLOSE  = 4'd6;
	localparam logic [3:0] K_OPER   = 4'd7;
	localparam logic [3:0] K_END    = 4'd8;
	localparam logic [3:0] K_UNTERM = 4'd9;
	localparam logic [3:0] K_GROUP  = 4'd10;

	// Source bytes with a meaning of their own.
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  lex_kind;
		logic [31:0] start_offset;
		logic [7:0]  lexeme_length;
		logic        too_long;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic [7:0] stop_char;
		logic       stop_enable;
	} cfg_t;

	// One token as produced by the front end.
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [7:0]  len;
		logic        tl;
	} tok_rec_t;

	// All tokens caused by one source byte: up to three, in order.
	typedef struct packed {
		logic [1:0]         count;
		tok_rec_t [2:0]     rec;
	} bundle_t;

endpackage

// File: rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner state machine: classifies each accepted byte and builds the bundle
// of tokens that it completes.
// ----------------------------------------------------------------------------
module stt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  stt_pkg::cfg_t     cfg,
	input  logic              acc,
	input  stt_pkg::in_item_t item,
	output stt_pkg::bundle_t  bundle,
	output logic              push
);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_NUM   = 3'd1;
	localparam logic [2:0] M_IDENT = 3'd2;
	localparam logic [2:0] M_STR   = 3'd3;
	localparam logic [2:0] M_OP    = 3'd4;

	logic [2:0]  mode_q, mode_d;
	logic [7:0]  pend_q, pend_d;
	logic [31:0] tstart_q, tstart_d;
	logic [7:0]  len_q, len_d;
	logic        ovf_q, ovf_d;
	logic [31:0] pos_q, pos_d;
	logic        chk_q, chk_d;
	logic        stop, do_start;
	logic [7:0]  b;
	stt_pkg::bundle_t bun;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == 8'h5F);
	endfunction

	function automatic stt_pkg::bundle_t put(input stt_pkg::bundle_t bi,
		input logic [3:0] k, input logic [31:0] s, input logic [7:0] l, input logic t);
		stt_pkg::bundle_t r;
		r = bi;
		r.rec[bi.count] = '{kind: k, start: s, len: l, tl: t};
		r.count = bi.count + 2'd1;
		return r;
	endfunction

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		tstart_d = tstart_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		chk_d    = chk_q;
		pos_d    = pos_q + 32'd1;
		bun      = '0;
		do_start = 1'b0;
		b        = item.char_byte;
		stop     = cfg.stop_enable && (b == cfg.stop_char);

		if (item.end_of_input) begin
			unique case (mode_q)
				M_NUM:   bun = put(bun, stt_pkg::K_INT, tstart_q, len_q, ovf_q);
				M_IDENT: bun = put(bun, stt_pkg::K_IDENT, tstart_q, len_q, ovf_q);
				M_STR:   bun = put(bun, stt_pkg::K_UNTERM, tstart_q, len_q, ovf_q);
				M_OP:    bun = put(bun, stt_pkg::K_OPER, tstart_q, 8'd1, 1'b0);
				default: bun = bun;
			endcase
			bun      = put(bun, stt_pkg::K_END, pos_q, 8'd0, 1'b0);
			mode_d   = M_IDLE;
			pend_d   = '0;
			tstart_d = '0;
			len_d    = '0;
			ovf_d    = 1'b0;
			pos_d    = '0;
			chk_d    = 1'b0;
		end else if (chk_q) begin
			chk_d = 1'b0;
			if (stop) begin
				bun = put(bun, stt_pkg::K_GROUP, pos_q, 8'd0, 1'b0);
			end
			do_start = 1'b1;
		end else begin
			unique case (mode_q) inside
				M_NUM, M_IDENT: begin
					if (is_digit(b) || (mode_q == M_IDENT && is_alpha(b))) begin
						if (len_q < stt_pkg::LEN_CAP) begin
							len_d = len_q + 8'd1;
						end else begin
							ovf_d = 1'b1;
						end
					end else begin
						bun = put(bun, (mode_q == M_NUM) ? stt_pkg::K_INT : stt_pkg::K_IDENT,
							tstart_q, len_q, ovf_q);
						mode_d = M_IDLE;
						if (stop) begin
							bun = put(bun, stt_pkg::K_GROUP, pos_q, 8'd0, 1'b0);
						end
						do_start = 1'b1;
					end
				end
				M_STR: begin
					if (b == stt_pkg::CH_QUOTE) begin
						bun    = put(bun, stt_pkg::K_STRING, tstart_q, len_q, ovf_q);
						mode_d = M_IDLE;
						chk_d  = 1'b1;
					end else if (len_q < stt_pkg::LEN_CAP) begin
						len_d = len_q + 8'd1;
					end else begin
						ovf_d = 1'b1;
					end
				end
				M_OP: begin
					if ((b == stt_pkg::CH_EQUAL) || ((b == pend_q) &&
						((pend_q == stt_pkg::CH_PLUS) || (pend_q == stt_pkg::CH_MINUS)))) begin
						bun    = put(bun, stt_pkg::K_OPER, tstart_q, 8'd2, 1'b0);
						mode_d = M_IDLE;
						chk_d  = 1'b1;
					end else begin
						bun    = put(bun, stt_pkg::K_OPER, tstart_q, 8'd1, 1'b0);
						len_d  = 8'd1;
						ovf_d  = 1'b0;
						mode_d = M_IDLE;
						if (stop) begin
							bun = put(bun, stt_pkg::K_GROUP, pos_q, 8'd0, 1'b0);
						end
						do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
		end

		// Opening of a new token by the current byte.
		if (do_start) begin
			if (is_digit(b) || is_alpha(b)) begin
				mode_d   = is_digit(b) ? M_NUM : M_IDENT;
				tstart_d = pos_q;
				len_d    = 8'd1;
				ovf_d    = 1'b0;
			end else if (b == stt_pkg::CH_QUOTE) begin
				mode_d   = M_STR;
				tstart_d = pos_q + 32'd1;
				len_d    = 8'd0;
				ovf_d    = 1'b0;
			end else if ((b == stt_pkg::CH_PLUS) || (b == stt_pkg::CH_MINUS) ||
				(b == stt_pkg::CH_STAR) || (b == stt_pkg::CH_SLASH)) begin
				mode_d   = M_OP;
				tstart_d = pos_q;
				len_d    = 8'd1;
				ovf_d    = 1'b0;
				pend_d   = b;
			end else if (b == stt_pkg::CH_SEMI) begin
				bun   = put(bun, stt_pkg::K_SEMI, pos_q, 8'd1, 1'b0);
				chk_d = 1'b1;
			end else if (b == stt_pkg::CH_COMMA) begin
				bun   = put(bun, stt_pkg::K_COMMA, pos_q, 8'd1, 1'b0);
				chk_d = 1'b1;
			end else if ((b == stt_pkg::CH_LPAREN) || (b == stt_pkg::CH_LBRACE)) begin
				bun   = put(bun, stt_pkg::K_OPEN, pos_q, 8'd1, 1'b0);
				chk_d = 1'b1;
			end else if ((b == stt_pkg::CH_RPAREN) || (b == stt_pkg::CH_RBRACE)) begin
				bun   = put(bun, stt_pkg::K_CLOSE, pos_q, 8'd1, 1'b0);
				chk_d = 1'b1;
			end
		end
	end

	assign bundle = bun;
	assign push   = acc && (bun.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			tstart_q <= '0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			pos_q    <= '0;
			chk_q    <= 1'b0;
		end else if (acc) begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			tstart_q <= tstart_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
			pos_q    <= pos_d;
			chk_q    <= chk_d;
		end
	end

	// End of input restarts the stream at offset zero with the scanner idle.
	a_eoi_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.end_of_input |=> (pos_q == 32'd0) && (mode_q == M_IDLE) && !chk_q)
		else $error("scanner not restarted after end of input");

	// Every end of input produces at least its end token.
	a_eoi_push: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.end_of_input |-> push)
		else $error("end of input without a token bundle");

endmodule

// File: rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short first-in first-out queue of token bundles between front and back end.
// ----------------------------------------------------------------------------
module stt_queue #(
	parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stt_pkg::bundle_t wr_data,
	input  logic             pop,
	output stt_pkg::bundle_t rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stt_pkg::bundle_t   mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("bundle queue read while empty");

endmodule

// File: rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Unpacks queued bundles into single tokens and holds each one in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module stt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  stt_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	output logic             tok_valid,
	input  logic             tok_stall,
	output stt_pkg::result_t tok_item
);

	logic             tok_valid_q;
	stt_pkg::result_t tok_q;
	logic [1:0]       idx_q;
	logic             load, is_last;
	stt_pkg::tok_rec_t cur;

	assign cur     = head.rec[idx_q];
	assign is_last = (idx_q == (head.count - 2'd1));
	assign load    = !empty && (!tok_valid_q || !tok_stall);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			tok_valid_q <= 1'b1;
			idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
		end else if (!tok_stall) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= '{lex_kind: cur.kind, start_offset: cur.start,
				lexeme_length: cur.len, too_long: cur.tl, last_result: is_last};
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_item  = tok_q;

	// A queued bundle always carries at least one token.
	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head.count != 2'd0) && (idx_q < head.count))
		else $error("token index outside queued bundle");

endmodule

// File: rtl/core/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial lexical tokenizer: integers, identifiers, strings, punctuation
// and arithmetic operators, with optional group-end markers on a stop byte.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload     Transfer when
//   source    src_valid / src_stall     src_item    valid high, stall low
//   token     tok_valid / tok_stall     tok_item    valid high, stall low
//   config    cfg_valid / cfg_ready     cfg_index,  valid and ready high
//                                       cfg_data
//
// One source byte is taken per clock cycle while the queue has room. The
// front end classifies the byte in the cycle of its transfer and writes the
// tokens that it completes (up to three) as one bundle into a short queue; the
// back end sends one token per cycle from the queue through a registered
// output while tok_stall is low. Sustained input rate is therefore one byte per
// cycle as long as bytes produce at most one token on average and tok_stall
// stays low; bursts of several tokens are absorbed by the queue, and the source
// sees stall only while the queue is full. Tokens are queued, then registered.
// Reset is asynchronous and active low; it clears the scanner, the queue and
// both configuration registers. Configuration writes are always accepted.
//
module source_text_tokenizer #(
	parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  stt_pkg::in_item_t              src_item,
	output logic                           tok_valid,
	input  logic                           tok_stall,
	output stt_pkg::result_t               tok_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);

	// Configuration registers: the user writes them only while the block is idle; not enforced.
	stt_pkg::cfg_t    cfg_q;
	logic             acc;
	logic             push, pop, full, empty;
	stt_pkg::bundle_t wr_bundle, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stt_pkg::CFG_STOP_CHAR:   cfg_q.stop_char   <= cfg_data;
				stt_pkg::CFG_STOP_ENABLE: cfg_q.stop_enable <= cfg_data[0];
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	// The source is held off only while the queue has no room for a bundle.
	assign src_stall = full;
	assign acc       = src_valid && !src_stall;

	// Front end: scanner state and token classification.
	stt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.acc    (acc),
		.item   (src_item),
		.bundle (wr_bundle),
		.push   (push)
	);

	// Decoupling queue of token bundles.
	stt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	// Back end: one token per transfer on the output channel.
	stt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the source text tokenizer. A byte-level model of
// the scanner predicts every token; random source bursts, random token stalls
// and several stop-byte settings drive the block through its token kinds.
// ----------------------------------------------------------------------------
module tb;

	// A run is declared hung when no transfer of any kind has happened for
	// this many cycles.
	localparam int QUIET_LIMIT = 2000;

	// Cycles allowed after the last token for bytes that cause no token.
	localparam int SETTLE_CYCLES = 10;

	// Stop-byte settings visited after the directed part. The fifth entry is
	// replaced with a random byte when its phase starts.
	localparam int PHASES = 6;
	localparam logic [7:0] PHASE_STOP[PHASES] = '{stt_pkg::CH_SEMI, 8'hFF, 8'h00,
		stt_pkg::CH_COMMA, 8'h00, 8'h00};
	localparam logic PHASE_ENABLE[PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

	localparam logic [7:0] PUNCT[6] = '{stt_pkg::CH_SEMI, stt_pkg::CH_COMMA,
		stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE};
	localparam logic [7:0] OPERS[4] = '{stt_pkg::CH_PLUS, stt_pkg::CH_MINUS,
		stt_pkg::CH_STAR, stt_pkg::CH_SLASH};

	typedef enum logic [2:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_STR, SCAN_OP} scan_mode_t;

	// ------------------------------------------------------------------------
	// Token ledger: a cycle-free model of the scanner. Every accepted source
	// byte is run through the model and the tokens that it completes are
	// queued; every token transfer on the output is checked against the
	// oldest queued token.
	// ------------------------------------------------------------------------
	class token_ledger;
		logic [7:0]       stop_byte;
		logic             stop_on;
		scan_mode_t       scan;
		logic [7:0]       op_byte;
		logic [31:0]      tok_start;
		logic [7:0]       tok_len;
		logic             tok_over;
		logic [31:0]      offset;
		logic             stop_armed;
		stt_pkg::result_t fresh[$];
		stt_pkg::result_t tokens_due[$];
		int               mismatches;

		function new();
			stop_byte = '0;
			stop_on = 1'b0;
			mismatches = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			scan = SCAN_IDLE;
			op_byte = '0;
			tok_start = '0;
			tok_len = '0;
			tok_over = 1'b0;
			offset = '0;
			stop_armed = 1'b0;
		endfunction

		function void set_register(logic [stt_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
			case (idx)
				stt_pkg::CFG_STOP_CHAR: stop_byte = data;
				stt_pkg::CFG_STOP_ENABLE: stop_on = data[0];
				default: ;
			endcase
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= 8'h30 && b <= 8'h39;
		endfunction

		function bit is_word(logic [7:0] b);
			return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
		endfunction

		function void emit(logic [3:0] kind, logic [31:0] start, logic [7:0] len, logic over);
			stt_pkg::result_t r;
			r.lex_kind = kind;
			r.start_offset = start;
			r.lexeme_length = len;
			r.too_long = over;
			r.last_result = 1'b0;
			fresh.push_back(r);
		endfunction

		function void enter_lexeme(logic [31:0] start, logic [7:0] len, scan_mode_t mode);
			scan = mode;
			tok_start = start;
			tok_len = len;
			tok_over = 1'b0;
		endfunction

		// The count saturates at the cap; anything beyond only sets the flag.
		function void grow();
			if (tok_len < stt_pkg::LEN_CAP)
				tok_len++;
			else
				tok_over = 1'b1;
		endfunction

		function void open_token(logic [7:0] b, logic [31:0] pos);
			logic [3:0] kind;
			if (is_digit(b)) begin
				enter_lexeme(pos, 8'd1, SCAN_NUM);
				return;
			end
			if (is_word(b)) begin
				enter_lexeme(pos, 8'd1, SCAN_IDENT);
				return;
			end
			case (b) inside
				stt_pkg::CH_QUOTE: begin
					enter_lexeme(pos + 32'd1, 8'd0, SCAN_STR);
					return;
				end
				stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR,
				stt_pkg::CH_SLASH: begin
					enter_lexeme(pos, 8'd1, SCAN_OP);
					op_byte = b;
					return;
				end
				stt_pkg::CH_SEMI: kind = stt_pkg::K_SEMI;
				stt_pkg::CH_COMMA: kind = stt_pkg::K_COMMA;
				stt_pkg::CH_LPAREN, stt_pkg::CH_LBRACE: kind = stt_pkg::K_OPEN;
				stt_pkg::CH_RPAREN, stt_pkg::CH_RBRACE: kind = stt_pkg::K_CLOSE;
				default: return;
			endcase
			emit(kind, pos, 8'd1, 1'b0);
			stop_armed = 1'b1;
		endfunction

		function void close_and_reopen(logic [7:0] b, logic [31:0] pos, logic stop,
				logic [3:0] kind, logic [7:0] len, logic over);
			emit(kind, tok_start, len, over);
			scan = SCAN_IDLE;
			if (stop)
				emit(stt_pkg::K_GROUP, pos, 8'd0, 1'b0);
			open_token(b, pos);
		endfunction

		function void take_byte(stt_pkg::in_item_t it);
			logic [7:0]  b;
			logic [31:0] pos;
			logic        stop;
			b = it.char_byte;
			pos = offset;
			fresh.delete();
			if (it.end_of_input) begin
				case (scan)
					SCAN_NUM: emit(stt_pkg::K_INT, tok_start, tok_len, tok_over);
					SCAN_IDENT: emit(stt_pkg::K_IDENT, tok_start, tok_len, tok_over);
					SCAN_STR: emit(stt_pkg::K_UNTERM, tok_start, tok_len, tok_over);
					SCAN_OP: emit(stt_pkg::K_OPER, tok_start, 8'd1, 1'b0);
					default: ;
				endcase
				emit(stt_pkg::K_END, pos, 8'd0, 1'b0);
				clear_stream();
			end else begin
				stop = stop_on && (b == stop_byte);
				if (stop_armed) begin
					stop_armed = 1'b0;
					if (stop)
						emit(stt_pkg::K_GROUP, pos, 8'd0, 1'b0);
					open_token(b, pos);
				end else begin
					case (scan)
						SCAN_NUM: begin
							if (is_digit(b))
								grow();
							else
								close_and_reopen(b, pos, stop, stt_pkg::K_INT, tok_len,
									tok_over);
						end
						SCAN_IDENT: begin
							if (is_word(b) || is_digit(b))
								grow();
							else
								close_and_reopen(b, pos, stop, stt_pkg::K_IDENT, tok_len,
									tok_over);
						end
						SCAN_STR: begin
							if (b == stt_pkg::CH_QUOTE) begin
								emit(stt_pkg::K_STRING, tok_start, tok_len, tok_over);
								scan = SCAN_IDLE;
								stop_armed = 1'b1;
							end else begin
								grow();
							end
						end
						SCAN_OP: begin
							if (b == stt_pkg::CH_EQUAL || (b == op_byte &&
									(op_byte == stt_pkg::CH_PLUS ||
									op_byte == stt_pkg::CH_MINUS))) begin
								emit(stt_pkg::K_OPER, tok_start, 8'd2, 1'b0);
								scan = SCAN_IDLE;
								stop_armed = 1'b1;
							end else begin
								close_and_reopen(b, pos, stop, stt_pkg::K_OPER, 8'd1, 1'b0);
							end
						end
						default: open_token(b, pos);
					endcase
				end
				offset = pos + 32'd1;
			end
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last_result = 1'b1;
			foreach (fresh[i])
				tokens_due.push_back(fresh[i]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: token %s: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void match_token(stt_pkg::result_t got);
			stt_pkg::result_t want;
			if (tokens_due.size() == 0) begin
				mismatches++;
				$display("%0t: token: expected none, actual kind %0d offset %0d length %0d",
					$time, got.lex_kind, got.start_offset, got.lexeme_length);
				return;
			end
			want = tokens_due.pop_front();
			compare_field("kind", 32'(want.lex_kind), 32'(got.lex_kind));
			compare_field("start_offset", want.start_offset, got.start_offset);
			compare_field("lexeme_length", 32'(want.lexeme_length), 32'(got.lexeme_length));
			compare_field("too_long", 32'(want.too_long), 32'(got.too_long));
			compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
		endfunction
	endclass

	// Every input of the block has a known value from time zero.
	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          src_valid = 1'b0;
	logic                          src_stall;
	stt_pkg::in_item_t             src_item = '0;
	logic                          tok_valid;
	logic                          tok_stall = 1'b0;
	stt_pkg::result_t              tok_item;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [stt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data = '0;

	token_ledger       ledger = new();
	stt_pkg::in_item_t script[$];
	logic [7:0]        cur_stop = 8'h00;
	logic              cur_enable = 1'b0;
	int                burst_left = 0;
	int                quiet = 0;
	int                style = 0;
	int                style_left = 0;
	int                beat = 0;

	source_text_tokenizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The token side stalls on a pattern of its own: it changes style at random
	// between never stalling, light and heavy random stalls, and a regular square
	// wave, so that stalls land on every phase of the block's output queue.
	always @(negedge clk) begin
		if (style_left == 0) begin
			style = $urandom_range(0, 3);
			style_left = $urandom_range(20, 120);
		end
		style_left--;
		beat++;
		case (style)
			0: tok_stall <= 1'b0;
			1: tok_stall <= ($urandom_range(0, 3) == 0);
			2: tok_stall <= ($urandom_range(0, 3) != 0);
			default: tok_stall <= (beat % 16) < 9;
		endcase
	end

	// Token transfers are checked at the rising edge. The same edge feeds the
	// watchdog, which only counts cycles in which no channel made a transfer.
	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall)
			ledger.match_token(tok_item);
		if ((src_valid && !src_stall) || (tok_valid && !tok_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Sends one source item. The sender works in bursts: once a burst is used
	// up it may drop valid for a random gap before the next one starts, and a
	// gap of zero joins two bursts into a longer stretch with no idling. Valid
	// stays high after a transfer; the next call either replaces the payload
	// or lowers valid at the following falling edge.
	task automatic send(input stt_pkg::in_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		ledger.take_byte(it);
	endtask

	task automatic play_script();
		foreach (script[i])
			send(script[i]);
		script.delete();
	endtask

	// Holds the source back until every predicted token has been seen, then
	// waits out the settle time for bytes that produced no token at all.
	task automatic drain();
		@(negedge clk);
		src_valid <= 1'b0;
		while (ledger.tokens_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [stt_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ledger.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		script.push_back(stt_pkg::in_item_t'{char_byte: b, end_of_input: 1'b0});
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void add_end();
		script.push_back(stt_pkg::in_item_t'{char_byte: 8'($urandom_range(0, 255)),
			end_of_input: 1'b1});
	endfunction

	function automatic logic [7:0] word_byte();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'h61 + 8'(r);
		if (r < 52)
			return 8'h41 + 8'(r - 26);
		return 8'h5F;
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] string_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == stt_pkg::CH_QUOTE);
		return c;
	endfunction

	// Appends one lexical chunk. Most chunks are well-formed tokens placed
	// back to back, so that each one ends the previous or runs on into it; stop
	// bytes, stray bytes, unclosed strings and end marks make up the rest.
	function automatic void compose_chunk();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = $urandom_range(1, 5);
			repeat (n) add_byte(digit_byte());
		end else if (r < 30) begin
			add_byte(word_byte());
			n = $urandom_range(0, 5);
			repeat (n) add_byte($urandom_range(0, 3) == 0 ? digit_byte() : word_byte());
		end else if (r < 40) begin
			add_byte(stt_pkg::CH_QUOTE);
			n = $urandom_range(0, 5);
			repeat (n) add_byte(string_byte());
			if ($urandom_range(0, 9) != 0)
				add_byte(stt_pkg::CH_QUOTE);
		end else if (r < 55) begin
			add_byte(PUNCT[$urandom_range(0, 5)]);
		end else if (r < 72) begin
			add_byte(OPERS[$urandom_range(0, 3)]);
			n = $urandom_range(0, 4);
			if (n < 2)
				add_byte(stt_pkg::CH_EQUAL);
			else if (n == 2)
				add_byte(script[script.size() - 1].char_byte);
		end else if (r < 82) begin
			add_byte(cur_stop);
		end else if (r < 94) begin
			add_byte(8'($urandom_range(0, 255)));
		end else if (r < 97) begin
			add_end();
		end else begin
			add_byte(8'h20);
		end
	endfunction

	task automatic run_random(input int count);
		while (count > 0) begin
			compose_chunk();
			count -= script.size();
			play_script();
		end
	endtask

	task automatic configure(input logic [7:0] stop, input logic enable);
		cur_stop = stop;
		cur_enable = enable;
		if ($urandom_range(0, 1) == 0) begin
			write_register(stt_pkg::CFG_STOP_CHAR, stop);
			write_register(stt_pkg::CFG_STOP_ENABLE, {7'd0, enable});
		end else begin
			write_register(stt_pkg::CFG_STOP_ENABLE, {7'd0, enable});
			write_register(stt_pkg::CFG_STOP_CHAR, stop);
		end
	endtask

	initial begin
		logic [7:0] stop;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed stream with the registers at their reset values: the byte
		// extremes, a number, an identifier, an empty string, every operator in
		// its single and double form, some punctuation, and an unclosed string
		// flushed by the end mark.
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("12;a_Z9\"\"++--+=-=*=/=+-*/,{)\"q");
		add_end();
		play_script();
		drain();

		// Random phases, each under its own stop-byte setting. The registers
		// are only written once the previous phase has fully drained, which
		// also gives the source the pause with nothing outstanding.
		for (int p = 0; p < PHASES; p++) begin
			stop = (p == 4) ? 8'($urandom_range(0, 255)) : PHASE_STOP[p];
			configure(stop, PHASE_ENABLE[p]);
			run_random(5);
			drain();
		end

		// Saturation: an identifier one byte past the cap, flushed by the end
		// mark.
		add_byte(word_byte());
		repeat (255) add_byte(word_byte());
		add_end();
		play_script();
		drain();

		if (ledger.mismatches == 0 && ledger.tokens_due.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
